/* design/cas_pkg.sv */
// Shared types, codes and calendar constants for the calendar alarm scheduler.
// No dependencies.
package cas_pkg;

  localparam int unsigned EPOCH_YEAR  = 2016;
  localparam int unsigned LEAPS_EPOCH = 488;   // leap years up to and including 2015
  localparam int unsigned SEC_W       = 42;    // signed seconds since the epoch
  localparam int unsigned MIN_W       = 35;    // signed minutes since the epoch
  localparam int unsigned DIV_W       = 40;    // dividend and quotient width
  localparam int unsigned DVS_W       = 16;    // divisor and remainder width
  localparam int unsigned IN_W        = 88;
  localparam int unsigned OUT_W       = 8;

  localparam logic [0:0] REQ_TICK = 1'b0;
  localparam logic [0:0] REQ_LOAD = 1'b1;

  localparam logic [2:0] KIND_OFF    = 3'd0;
  localparam logic [2:0] KIND_ONCE   = 3'd1;
  localparam logic [2:0] KIND_REPEAT = 3'd2;
  localparam logic [2:0] KIND_DUR    = 3'd3;
  localparam logic [2:0] KIND_DUR_SE = 3'd4;

  localparam logic [1:0] ACT_MAIN  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [4:0] HOUR_ANY = 5'd24;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  typedef struct packed {
    logic [2:0]  kind;
    cal_t        cal;
    logic [6:0]  week_mask;
    logic [15:0] interval;
    logic [15:0] duration;
  } slot_t;

  // Days before the first of a month in a common year; months past 12 count the whole year.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    begin
      case (m)
        4'd0, 4'd1: r = 9'd0;
        4'd2:       r = 9'd31;
        4'd3:       r = 9'd59;
        4'd4:       r = 9'd90;
        4'd5:       r = 9'd120;
        4'd6:       r = 9'd151;
        4'd7:       r = 9'd181;
        4'd8:       r = 9'd212;
        4'd9:       r = 9'd243;
        4'd10:      r = 9'd273;
        4'd11:      r = 9'd304;
        4'd12:      r = 9'd334;
        default:    r = 9'd365;
      endcase
      return r;
    end
  endfunction

endpackage

/* design/cas_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* design/cas_epoch.sv */
// Five-stage pipeline turning a calendar time into seconds and minutes since 2016-01-01.
// Depends on cas_pkg.
module cas_epoch (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  cas_pkg::cal_t              cal_i,
  output logic                       done_o,
  output logic                       ok_o,
  output logic signed [cas_pkg::SEC_W-1:0] secs_o,
  output logic signed [cas_pkg::MIN_W-1:0] mins_o,
  output logic [5:0]                 sec_o
);
  import cas_pkg::*;

  logic [4:0]  vld_q;
  cal_t        c1_q, c2_q, c3_q, c4_q;
  logic        yok1_q, yok2_q, yok3_q, yok4_q, yok5_q;
  logic [11:0] dy1_q;
  logic [8:0]  leaps1_q;
  logic        leap1_q;
  logic signed [23:0] days_q;
  logic signed [28:0] hrs_q;
  logic signed [MIN_W-1:0] mins_q, mins5_q;
  logic [5:0]  sec5_q;
  logic signed [SEC_W-1:0] secs_q;

  // year-derived terms; /100 and /400 by reciprocal multiply (exact below 1024*4)
  logic [11:0] y, n, r100, r400;
  logic [15:0] py, pn;
  logic [13:0] py4, pn4;
  logic [11:0] leaps_w;
  logic        leap_w;
  always_comb begin
    y    = cal_i.year;
    n    = y - 12'd1;
    py   = 16'(y[11:2]) * 16'd41;
    py4  = 14'(y[11:4]) * 14'd41;
    pn   = 16'(n[11:2]) * 16'd41;
    pn4  = 14'(n[11:4]) * 14'd41;
    r100 = y - 12'(py[15:10]) * 12'd100;
    r400 = y - 12'(py4[13:10]) * 12'd400;
    leap_w  = ((y[1:0] == 2'd0) && (r100 != 12'd0)) || (r400 == 12'd0);
    leaps_w = 12'(n[11:2]) - 12'(pn[15:10]) + 12'(pn4[13:10]) - 12'(LEAPS_EPOCH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q     <= cal_i;
    yok1_q   <= (cal_i.year >= 12'(EPOCH_YEAR));
    dy1_q    <= cal_i.year - 12'(EPOCH_YEAR);
    leaps1_q <= leaps_w[8:0];
    leap1_q  <= leap_w;

    c2_q   <= c1_q;
    yok2_q <= yok1_q;
    days_q <= 24'(dy1_q) * 24'd365 + 24'(leaps1_q) + 24'(cum_days(c1_q.month))
              + 24'(leap1_q && (c1_q.month >= 4'd3)) + 24'(c1_q.day) - 24'd1;

    c3_q   <= c2_q;
    yok3_q <= yok2_q;
    hrs_q  <= 29'(days_q) * 29'sd24 + 29'(c2_q.hour);

    c4_q   <= c3_q;
    yok4_q <= yok3_q;
    mins_q <= MIN_W'(hrs_q) * 35'sd60 + MIN_W'(c3_q.minute);

    yok5_q  <= yok4_q;
    mins5_q <= mins_q;
    sec5_q  <= c4_q.second;
    secs_q  <= SEC_W'(mins_q) * SEC_W'(60) + SEC_W'(c4_q.second);
  end

  assign done_o = vld_q[4];
  assign secs_o = secs_q;
  assign mins_o = mins5_q;
  assign sec_o  = sec5_q;
  assign ok_o   = yok5_q && (secs_q > 0);
endmodule

/* design/cas_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle; gives the remainder only.
// Depends on cas_pkg.
module cas_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cas_pkg::DIV_W-1:0]   dividend_i,
  input  logic [cas_pkg::DVS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [cas_pkg::DVS_W-1:0]   rem_o
);
  import cas_pkg::*;

  localparam int unsigned CW = $clog2(DIV_W);

  logic            busy_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic [DIV_W-1:0] dq_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [DVS_W:0]  trial, diff;
  logic            ge;

  always_comb begin
    trial = {rem_q, dq_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

/* design/calendar_alarm_scheduler_unit.sv */
// Calendar alarm scheduler: timer slot table scanned once per tick beat.
// A load beat is taken while idle. A tick first converts its own time, then checks each
// slot in turn, converting the slot start time and running the shared divider on duration
// slots, and sends the result beats, waiting while the output side stalls. One item at a
// time. Reset clears the slot valid bits, so every slot starts off.
// Depends on cas_pkg, cas_ram, cas_epoch and cas_div.
module calendar_alarm_scheduler_unit #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // slot, kind, year, month, day, hour, minute, second, weekday_or_mask,
  // interval_minutes, duration_minutes (from bit 0 up), zero padded
  input  logic [cas_pkg::IN_W-1:0]     s_axis_tdata,
  input  logic                         s_axis_tuser,   // req_type
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cas_pkg::OUT_W-1:0]    m_axis_tdata,   // fired_slot, action, zero padded
  output logic                         m_axis_tlast    // last
);
  import cas_pkg::*;

  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NOW, ST_RD, ST_CHK, ST_EP, ST_DIV, ST_OUT, ST_ADV
  } state_e;

  state_e            state_q;
  logic [SW-1:0]     idx_q;
  logic [SLOT_COUNT-1:0] valid_q;
  cal_t              t_cal_q;
  logic [6:0]        t_wk_q;
  logic signed [SEC_W-1:0] now_q;
  logic signed [MIN_W-1:0] now_min_q;
  logic [5:0]        now_sec_q;
  logic              now_ok_q;
  logic              pend_v_q;
  logic [2:0]        pend_slot_q;
  logic [1:0]        pend_act_q;
  logic              m_valid_q, m_last_q, final_q;
  logic [2:0]        m_slot_q;
  logic [1:0]        m_act_q;

  // input unpack
  slot_t       in_slot;
  logic [2:0]  in_idx;
  logic        in_acc, in_range;
  logic [6:0]  in_idx_ext;
  always_comb begin
    in_idx               = s_axis_tdata[2:0];
    in_slot.kind         = (s_axis_tdata[5:3] <= KIND_DUR_SE) ? s_axis_tdata[5:3] : KIND_OFF;
    in_slot.cal.year     = s_axis_tdata[17:6];
    in_slot.cal.month    = s_axis_tdata[21:18];
    in_slot.cal.day      = s_axis_tdata[26:22];
    in_slot.cal.hour     = s_axis_tdata[31:27];
    in_slot.cal.minute   = s_axis_tdata[37:32];
    in_slot.cal.second   = s_axis_tdata[43:38];
    in_slot.week_mask    = s_axis_tdata[50:44];
    in_slot.interval     = s_axis_tdata[66:51];
    in_slot.duration     = s_axis_tdata[82:67];
    in_idx_ext           = {4'd0, in_idx};
    in_range             = (32'(in_idx) < SLOT_COUNT);
    in_acc               = s_axis_tvalid && s_axis_tready;
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // slot table
  slot_t rd;
  logic  ram_we;
  assign ram_we = in_acc && (s_axis_tuser == REQ_LOAD) && in_range;

  cas_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOT_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_idx_ext[SW-1:0]),
    .wdata_i (in_slot),
    .raddr_i (idx_q),
    .rdata_o (rd)
  );

  // epoch unit, shared by tick time and slot start time
  logic ep_start, ep_done, ep_ok;
  logic signed [SEC_W-1:0] ep_secs;
  logic signed [MIN_W-1:0] ep_mins;
  logic [5:0] ep_sec;
  cal_t ep_cal;
  logic chk_dur;
  always_comb begin
    chk_dur  = (state_q == ST_CHK) && valid_q[idx_q] &&
               ((rd.kind == KIND_DUR) || (rd.kind == KIND_DUR_SE));
    ep_start = (in_acc && (s_axis_tuser == REQ_TICK)) || chk_dur;
    ep_cal   = (state_q == ST_IDLE) ? in_slot.cal : rd.cal;
  end

  cas_epoch u_epoch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ep_start),
    .cal_i   (ep_cal),
    .done_o  (ep_done),
    .ok_o    (ep_ok),
    .secs_o  (ep_secs),
    .mins_o  (ep_mins),
    .sec_o   (ep_sec)
  );

  // divider: elapsed minutes mod interval; the whole minutes come from the minute counts,
  // corrected by one where the second fields differ by a full minute
  logic signed [MIN_W-1:0] min_diff, el_min;
  logic signed [6:0] sec_diff;
  logic sec_hi, sec_lo, ehit;
  logic dur_ok, div_start, div_done;
  logic [DIV_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs, div_rem;
  always_comb begin
    min_diff  = now_min_q - ep_mins;
    sec_diff  = $signed({1'b0, now_sec_q}) - $signed({1'b0, ep_sec});
    sec_hi    = (sec_diff == 7'sd60);
    sec_lo    = (sec_diff == -7'sd60);
    el_min    = min_diff;
    if (sec_hi) el_min = min_diff + MIN_W'(1);
    else if (sec_lo) el_min = min_diff - MIN_W'(1);
    dur_ok    = now_ok_q && ep_ok && (ep_secs <= now_q) && (rd.interval != 16'd0);
    ehit      = dur_ok && (sec_hi || sec_lo || (sec_diff == 7'sd0));
    div_start = (state_q == ST_EP) && ep_done && ehit;
    div_dvd   = DIV_W'(el_min);
    div_dvs   = rd.interval;
  end

  cas_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // firing decision for the current slot
  logic       fire, once_hit, rep_hit;
  logic [1:0] fire_act;
  always_comb begin
    once_hit = (rd.cal.year == t_cal_q.year) && (rd.cal.month == t_cal_q.month) &&
               (rd.cal.day == t_cal_q.day) && (rd.cal.hour == t_cal_q.hour) &&
               (rd.cal.minute == t_cal_q.minute) && (t_cal_q.second == 6'd0);
    rep_hit  = (t_wk_q < 7'd7) && rd.week_mask[t_wk_q[2:0]] &&
               ((rd.cal.hour == t_cal_q.hour) || (rd.cal.hour == HOUR_ANY)) &&
               (rd.cal.minute == t_cal_q.minute) && (t_cal_q.second == 6'd0);
    fire     = 1'b0;
    fire_act = ACT_MAIN;
    case (state_q)
      ST_CHK: begin
        if (valid_q[idx_q]) begin
          fire = ((rd.kind == KIND_ONCE) && once_hit) ||
                 ((rd.kind == KIND_REPEAT) && rep_hit);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            fire     = 1'b1;
            fire_act = (rd.kind == KIND_DUR) ? ACT_MAIN : ACT_START;
          end else if ((rd.duration != 16'd0) && (div_rem == rd.duration)) begin
            fire     = 1'b1;
            fire_act = ACT_END;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      valid_q   <= '0;
      pend_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
      final_q   <= 1'b0;
      now_ok_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == REQ_LOAD) begin
              if (in_range) valid_q[in_idx_ext[SW-1:0]] <= 1'b1;
            end else begin
              t_cal_q <= in_slot.cal;
              t_wk_q  <= in_slot.week_mask;
              idx_q   <= '0;
              state_q <= ST_NOW;
            end
          end
        end
        ST_NOW: begin
          if (ep_done) begin
            now_q     <= ep_secs;
            now_min_q <= ep_mins;
            now_sec_q <= ep_sec;
            now_ok_q  <= ep_ok;
            state_q   <= ST_RD;
          end
        end
        ST_RD: state_q <= ST_CHK;
        ST_CHK: begin
          if (chk_dur) begin
            state_q <= ST_EP;
          end else if (!fire) begin
            state_q <= ST_ADV;
          end else if (rd.kind == KIND_ONCE) begin
            valid_q[idx_q] <= 1'b0;   // one-shot turns itself off
          end
        end
        ST_EP: begin
          if (ep_done) state_q <= ehit ? ST_DIV : ST_ADV;
        end
        ST_DIV: begin
          if (div_done && !fire) state_q <= ST_ADV;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_valid_q <= 1'b0;
            state_q   <= final_q ? ST_IDLE : ST_ADV;
          end
        end
        ST_ADV: begin
          if (idx_q == SW'(SLOT_COUNT - 1)) begin
            idx_q <= '0;
            if (pend_v_q) begin
              m_slot_q  <= pend_slot_q;
              m_act_q   <= pend_act_q;
              m_last_q  <= 1'b1;
              m_valid_q <= 1'b1;
              final_q   <= 1'b1;
              pend_v_q  <= 1'b0;
              state_q   <= ST_OUT;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            idx_q   <= idx_q + SW'(1);
            state_q <= ST_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // hold a hit back until the next one shows whether it is the last
      if (fire) begin
        pend_v_q    <= 1'b1;
        pend_slot_q <= 3'(idx_q);
        pend_act_q  <= fire_act;
        if (pend_v_q) begin
          m_slot_q  <= pend_slot_q;
          m_act_q   <= pend_act_q;
          m_last_q  <= 1'b0;
          m_valid_q <= 1'b1;
          final_q   <= 1'b0;
          state_q   <= ST_OUT;
        end else begin
          state_q <= ST_ADV;
        end
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'd0, m_act_q, m_slot_q};
  assign m_axis_tlast  = m_last_q;
endmodule

/* tb/alarm_checker.sv */
// Checker for calendar_alarm_scheduler_unit: watches both stream channels, keeps its own
// slot table, works out the firings of each tick beat and compares them in order.
// Depends on cas_pkg for codes and widths.
`timescale 1ns / 1ps
module alarm_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [cas_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                      s_axis_tuser,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [cas_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      m_axis_tlast,
  output int                        fail_count_o,
  output int                        pending_o
);
  import cas_pkg::*;

  typedef struct {
    logic [2:0] fired_slot;
    logic [1:0] action;
    logic       last;
  } firing_t;

  logic [2:0]  tbl_kind   [8];
  logic [11:0] tbl_year   [8];
  logic [3:0]  tbl_month  [8];
  logic [4:0]  tbl_day    [8];
  logic [4:0]  tbl_hour   [8];
  logic [5:0]  tbl_minute [8];
  logic [5:0]  tbl_second [8];
  logic [6:0]  tbl_mask   [8];
  logic [15:0] tbl_ival   [8];
  logic [15:0] tbl_dur    [8];

  firing_t firings_due[$];

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_in(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Seconds since 2016-01-01; zero or below is invalid.
  function automatic longint epoch_secs(int unsigned y, int unsigned mo, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned s);
    longint days;
    days = 0;
    if (y < EPOCH_YEAR) return 0;
    for (int unsigned k = EPOCH_YEAR; k < y; k++) days += is_leap(k) ? 366 : 365;
    for (int unsigned k = 1; k < mo; k++) days += days_in(y, k);
    days += longint'(d) - 1;
    return ((days * 24 + h) * 60 + mi) * 60 + s;
  endfunction

  task automatic take_item(input logic req, input logic [IN_W-1:0] d);
    logic [2:0]  sl, kd;
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy, hr;
    logic [5:0]  mi, se;
    logic [6:0]  wk;
    logic [15:0] iv, du;
    longint      now, st, el, rem;
    int          act, n;
    firing_t     f;
    {du, iv, wk, se, mi, hr, dy, mo, yr, kd, sl} = d[82:0];
    if (req == REQ_LOAD) begin
      tbl_kind[sl]   = (kd <= KIND_DUR_SE) ? kd : KIND_OFF;
      tbl_year[sl]   = yr;  tbl_month[sl]  = mo; tbl_day[sl]  = dy;
      tbl_hour[sl]   = hr;  tbl_minute[sl] = mi; tbl_second[sl] = se;
      tbl_mask[sl]   = wk;  tbl_ival[sl]   = iv; tbl_dur[sl]  = du;
      return;
    end
    now = epoch_secs(yr, mo, dy, hr, mi, se);
    n = 0;
    for (int i = 0; i < 8; i++) begin
      act = -1;
      case (tbl_kind[i])
        KIND_ONCE: begin
          if (tbl_year[i] == yr && tbl_month[i] == mo && tbl_day[i] == dy &&
              tbl_hour[i] == hr && tbl_minute[i] == mi && se == 0) begin
            act = ACT_MAIN;
            tbl_kind[i] = KIND_OFF;
          end
        end
        KIND_REPEAT: begin
          if (wk < 7 && tbl_mask[i][wk] && (tbl_hour[i] == hr || tbl_hour[i] == HOUR_ANY) &&
              tbl_minute[i] == mi && se == 0)
            act = ACT_MAIN;
        end
        KIND_DUR, KIND_DUR_SE: begin
          st = epoch_secs(tbl_year[i], tbl_month[i], tbl_day[i], tbl_hour[i],
                          tbl_minute[i], tbl_second[i]);
          if (now > 0 && st > 0 && st <= now && tbl_ival[i] != 0) begin
            el  = now - st;
            rem = (el / 60) % tbl_ival[i];
            if (el % 60 == 0) begin
              if (rem == 0) act = (tbl_kind[i] == KIND_DUR) ? ACT_MAIN : ACT_START;
              else if (tbl_dur[i] != 0 && rem == tbl_dur[i]) act = ACT_END;
            end
          end
        end
        default: ;
      endcase
      if (act >= 0) begin
        f.fired_slot = i[2:0];
        f.action     = act[1:0];
        f.last       = 1'b0;
        firings_due.push_back(f);
        n++;
      end
    end
    if (n > 0) firings_due[$].last = 1'b1;
  endtask

  always @(posedge clk_i) begin
    firing_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      pending_o    <= 0;
      firings_due.delete();
      for (int i = 0; i < 8; i++) tbl_kind[i] = KIND_OFF;
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (firings_due.size() == 0) begin
          $display("%0t: unexpected beat slot=%0d action=%0d last=%0b", $time,
                   m_axis_tdata[2:0], m_axis_tdata[4:3], m_axis_tlast);
          fail_count_o++;
        end else begin
          e = firings_due.pop_front();
          if (m_axis_tdata[2:0] !== e.fired_slot || m_axis_tdata[4:3] !== e.action ||
              m_axis_tdata[7:5] !== 3'b000 || m_axis_tlast !== e.last) begin
            $display("%0t: mismatch expected slot=%0d action=%0d last=%0b, got slot=%0d action=%0d last=%0b pad=%0h",
                     $time, e.fired_slot, e.action, e.last, m_axis_tdata[2:0],
                     m_axis_tdata[4:3], m_axis_tlast, m_axis_tdata[7:5]);
            fail_count_o++;
          end
        end
      end
      pending_o <= firings_due.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the scheduler testbench: clock, reset, stimulus and verdict.
// Depends on cas_pkg, calendar_alarm_scheduler_unit and alarm_checker.
`timescale 1ns / 1ps
module testbench;
  import cas_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;
  int                fail_count, pending;
  int                send_idle_pct = 0, recv_idle_pct = 0;

  // what has been loaded, used only to aim ticks at slots
  logic [2:0]  aim_kind [8];
  cal_t        aim_cal  [8];
  logic [15:0] aim_ival [8];
  logic [15:0] aim_dur  [8];

  calendar_alarm_scheduler_unit #(.SLOT_COUNT(8)) uut (.*);

  alarm_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one beat, hold it until taken, then maybe idle.
  task automatic send(input logic req, input logic [2:0] sl, input logic [2:0] kd,
                      input cal_t c, input logic [6:0] wk, input logic [15:0] iv,
                      input logic [15:0] du);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {5'b0, du, iv, wk, c.second, c.minute, c.hour, c.day, c.month, c.year,
                      kd, sl};
    if (req == REQ_LOAD) begin
      aim_kind[sl] = kd; aim_cal[sl] = c; aim_ival[sl] = iv; aim_dur[sl] = du;
    end
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  function automatic cal_t mk_cal(int y, int mo, int d, int h, int mi, int s);
    cal_t c;
    c.year = 12'(y); c.month = 4'(mo); c.day = 5'(d); c.hour = 5'(h);
    c.minute = 6'(mi); c.second = 6'(s);
    return c;
  endfunction

  task automatic random_load();
    logic [2:0]  kd;
    cal_t        c;
    logic [15:0] iv, du;
    kd = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
    c  = mk_cal($urandom_range(2016, 2030), $urandom_range(1, 12), $urandom_range(1, 28),
                $urandom_range(0, 23), $urandom_range(0, 59), 0);
    if (kd == KIND_REPEAT && $urandom_range(4) == 0) c.hour = HOUR_ANY;
    if (kd >= KIND_DUR) c.second = 6'($urandom_range(0, 59));
    iv = 16'($urandom_range(1, 12));
    case ($urandom_range(19))
      0:       iv = 16'd0;
      1:       iv = 16'($urandom);
      default: ;
    endcase
    du = 16'($urandom_range(0, iv));
    if ($urandom_range(9) == 0) du = 16'($urandom);
    send(REQ_LOAD, 3'($urandom), kd, c, 7'($urandom), iv, du);
  endtask

  task automatic random_tick();
    int   j, off, mins;
    cal_t c;
    if ($urandom_range(9) < 7) begin
      j = $urandom_range(7);
      c = aim_cal[j];
      if (aim_kind[j] >= KIND_DUR) begin
        off = aim_ival[j] * $urandom_range(0, 3);
        if ($urandom_range(1)) off += aim_dur[j];
        if ($urandom_range(5) == 0) off = $urandom_range(0, 200);
        mins = c.hour * 60 + c.minute + off;
        if (c.hour < 24 && mins < 1440) begin
          c.hour = 5'(mins / 60); c.minute = 6'(mins % 60);
        end
      end else begin
        if (c.hour == HOUR_ANY) c.hour = 5'($urandom_range(0, 23));
        c.second = 6'd0;
      end
      if ($urandom_range(9) == 0) c.second = 6'($urandom_range(0, 59));
      send(REQ_TICK, 3'($urandom), 3'($urandom), c,
           ($urandom_range(19) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6)),
           16'($urandom), 16'($urandom));
    end else begin
      c = mk_cal($urandom_range(0, 2135), $urandom, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(1)) c = mk_cal($urandom_range(2016, 2030), $urandom_range(1, 12),
                                        $urandom_range(1, 28), $urandom_range(0, 23),
                                        $urandom_range(0, 59), 0);
      send(REQ_TICK, 3'($urandom), 3'($urandom), c, 7'($urandom), 16'($urandom),
           16'($urandom));
    end
  endtask

  initial begin
    int guard;
    for (int i = 0; i < 8; i++) begin
      aim_kind[i] = KIND_OFF; aim_cal[i] = '0; aim_ival[i] = '0; aim_dur[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every kind, extremes, odd calendar values
    send(REQ_TICK, 0, 0, mk_cal(2020, 5, 5, 5, 5, 0), 3, 0, 0);
    send(REQ_LOAD, 0, KIND_ONCE,   mk_cal(2135, 12, 31, 23, 59, 0), 7'h00, 0, 0);
    send(REQ_LOAD, 1, KIND_REPEAT, mk_cal(0, 0, 0, HOUR_ANY, 30, 0), 7'h7f, 0, 0);
    send(REQ_LOAD, 2, KIND_DUR,    mk_cal(2016, 1, 1, 0, 0, 0), 0, 0, 0);
    send(REQ_LOAD, 3, KIND_DUR_SE, mk_cal(2016, 1, 1, 0, 0, 1), 0, 10, 3);
    send(REQ_LOAD, 4, KIND_DUR,    mk_cal(2016, 2, 28, 23, 0, 0), 0, 0, 0);
    send(REQ_LOAD, 5, KIND_DUR,    mk_cal(2015, 12, 31, 0, 0, 0), 0, 5, 0);
    send(REQ_LOAD, 6, 3'd7,        mk_cal(2020, 1, 1, 0, 0, 0), 7'h7f, 1, 1);
    send(REQ_LOAD, 7, KIND_DUR_SE, mk_cal(2016, 0, 0, 0, 0, 0), 0, 16'hffff, 16'hffff);
    send(REQ_TICK, 0, 0, mk_cal(2135, 12, 31, 23, 59, 0), 6, 0, 0);
    send(REQ_TICK, 0, 0, mk_cal(2135, 12, 31, 23, 59, 0), 6, 0, 0);
    send(REQ_TICK, 0, 0, mk_cal(2016, 1, 1, 0, 30, 0), 0, 0, 0);
    send(REQ_TICK, 0, 0, mk_cal(2016, 1, 1, 0, 30, 1), 0, 0, 0);
    send(REQ_TICK, 0, 0, mk_cal(2016, 1, 1, 7, 30, 0), 7, 0, 0);
    send(REQ_TICK, 0, 0, mk_cal(2016, 1, 1, 0, 10, 1), 2, 0, 0);
    send(REQ_TICK, 0, 0, mk_cal(2016, 1, 1, 0, 13, 1), 2, 0, 0);
    send(REQ_TICK, 0, 0, mk_cal(2016, 15, 31, 31, 63, 63), 7'h7f, 16'hffff, 16'hffff);
    send(REQ_LOAD, 2, KIND_DUR,    mk_cal(2016, 1, 1, 0, 0, 0), 0, 7, 2);
    send(REQ_TICK, 0, 0, mk_cal(2016, 3, 1, 0, 2, 0), 1, 0, 0);
    send(REQ_TICK, 0, 0, mk_cal(2015, 6, 1, 0, 0, 0), 1, 0, 0);
    send(REQ_LOAD, 7, KIND_DUR_SE, mk_cal(2016, 0, 0, 0, 0, 0), 0, 0, 5);
    send(REQ_TICK, 0, 0, mk_cal(2016, 1, 1, 0, 0, 0), 0, 0, 0);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 35 : (p == 1) ? 87 : 0;
      recv_idle_pct = (p == 0) ? 87 : (p == 1) ? 35 : 0;
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(3) == 0) random_load();
        else random_tick();
      end
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (1000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
